/* rtl/core/btpc_pkg.sv */
// Shared types and constants for the barometric compensation block.
package btpc_pkg;

    localparam int DIV_W     = 64;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_COEFFS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_COEFFS_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_COEFFS_B = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_COEFF_P9 = 2'd3;

    localparam logic signed [63:0] V1_OFFSET   = 64'sd128000;
    localparam logic signed [63:0] PRESS_SCALE = 64'sd3125;
    localparam logic [20:0]        PRESS_FULL  = 21'd1048576;
    localparam logic signed [31:0] TC_ROUND    = 32'sd128;
    localparam logic signed [63:0] X_BIAS      = 64'sh0000_8000_0000_0000;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } coeff_t;

    // results that ride along with the divider
    typedef struct packed {
        logic signed [31:0] tc;
        logic signed [31:0] tf;
        logic               invalid;
        logic               neg;
    } side_t;

    typedef struct packed {
        logic             valid;
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] work;
        logic [DIV_W-1:0] den;
        side_t            side;
    } div_stage_t;

endpackage

/* rtl/core/btpc_front.sv */
// Temperature path and pressure divisor/dividend pipeline feeding the divider.
module btpc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [19:0]         raw_pressure,
    input  logic [19:0]         raw_temperature,
    input  btpc_pkg::coeff_t    coeff,
    output btpc_pkg::div_stage_t div_out
);
    import btpc_pkg::*;

    localparam int NSTG = 11;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;

    logic [19:0]        adcp_reg [1:8];
    logic signed [31:0] tf_reg   [4:10];
    logic signed [31:0] tc_reg   [5:10];

    logic signed [31:0] s1_a1_reg, s1_d_reg;
    logic signed [31:0] s2_m1_reg, s2_dd_reg;
    logic signed [31:0] s3_tv1_reg, s3_m2_reg;
    logic signed [63:0] s5_v1_reg;
    logic signed [63:0] s6_vsq_reg, s6_vp5_reg, s6_vp2_reg;
    logic signed [63:0] s7_v2a_reg, s7_vs3_reg, s7_part_reg, s7_vp2_reg;
    logic signed [63:0] s8_v2_reg, s8_x_reg;
    logic signed [63:0] s9_y_reg, s9_n0_reg;
    logic signed [63:0] s10_den_reg, s10_num_reg;
    div_stage_t         out_reg;

    logic signed [31:0] sq;
    logic signed [67:0] vsq_full;
    logic [20:0]        praw;
    div_stage_t         out_next;

    assign vld_next = {vld_reg[NSTG-2:0], in_valid};
    assign sq       = s2_dd_reg >>> 12;
    assign vsq_full = $signed(s5_v1_reg[33:0]) * $signed(s5_v1_reg[33:0]);
    assign praw     = PRESS_FULL - {1'b0, adcp_reg[8]};

    always_comb
    begin
        out_next             = '0;
        out_next.valid       = vld_reg[NSTG-2];
        out_next.rem         = '0;
        out_next.work        = s10_num_reg[63] ? 64'(-s10_num_reg) : s10_num_reg;
        out_next.den         = s10_den_reg[63] ? 64'(-s10_den_reg) : s10_den_reg;
        out_next.side.tc     = tc_reg[10] >>> 8;
        out_next.side.tf     = tf_reg[10];
        out_next.side.invalid = (s10_den_reg == '0);
        out_next.side.neg    = s10_num_reg[63] ^ s10_den_reg[63];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            adcp_reg[1] <= raw_pressure;
            for (int k = 2; k <= 8; k++)
            begin
                adcp_reg[k] <= adcp_reg[k-1];
            end
            s1_a1_reg <= $signed({15'b0, raw_temperature[19:3]}) - $signed({15'b0, coeff.t1, 1'b0});
            s1_d_reg  <= $signed({16'b0, raw_temperature[19:4]}) - $signed({16'b0, coeff.t1});
            s2_m1_reg <= s1_a1_reg * 32'(coeff.t2);
            s2_dd_reg <= s1_d_reg * s1_d_reg;
            s3_tv1_reg <= s2_m1_reg >>> 11;
            s3_m2_reg  <= sq * 32'(coeff.t3);
            tf_reg[4]  <= s3_tv1_reg + (s3_m2_reg >>> 14);
            for (int k = 5; k <= 10; k++)
            begin
                tf_reg[k] <= tf_reg[k-1];
            end
            tc_reg[5] <= tf_reg[4] * 32'sd5 + TC_ROUND;
            for (int k = 6; k <= 10; k++)
            begin
                tc_reg[k] <= tc_reg[k-1];
            end
            s5_v1_reg  <= 64'(tf_reg[4]) - V1_OFFSET;
            s6_vsq_reg <= vsq_full[63:0];
            s6_vp5_reg <= $signed(s5_v1_reg[33:0]) * coeff.p5;
            s6_vp2_reg <= $signed(s5_v1_reg[33:0]) * coeff.p2;
            s7_v2a_reg  <= s6_vsq_reg * 64'(coeff.p6);
            s7_vs3_reg  <= s6_vsq_reg * 64'(coeff.p3);
            s7_part_reg <= (s6_vp5_reg <<< 17) + (64'(coeff.p4) <<< 35);
            s7_vp2_reg  <= s6_vp2_reg;
            s8_v2_reg <= s7_v2a_reg + s7_part_reg;
            s8_x_reg  <= X_BIAS + (s7_vs3_reg >>> 8) + (s7_vp2_reg <<< 12);
            s9_y_reg  <= s8_x_reg * $signed({48'b0, coeff.p1});
            s9_n0_reg <= $signed({43'b0, praw} << 31) - s8_v2_reg;
            s10_den_reg <= s9_y_reg >>> 33;
            s10_num_reg <= s9_n0_reg * PRESS_SCALE;
            out_reg <= out_next;
        end
    end

    always_comb
    begin
        div_out       = out_reg;
        div_out.valid = vld_reg[NSTG-1];
    end

endmodule

/* rtl/core/btpc_div_cell.sv */
// One restoring-division cell: one quotient bit per item per cycle while en is high.
module btpc_div_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  btpc_pkg::div_stage_t d_in,
    output btpc_pkg::div_stage_t d_out
);
    import btpc_pkg::*;

    logic             valid_reg;
    div_stage_t       data_reg;
    div_stage_t       data_next;
    logic [DIV_W-1:0] trial;
    logic             ge;

    // rem < den <= 2^63, so the shifted remainder fits
    assign trial = {d_in.rem[DIV_W-2:0], d_in.work[DIV_W-1]};
    assign ge    = (trial >= d_in.den);

    always_comb
    begin
        data_next      = d_in;
        data_next.rem  = ge ? (trial - d_in.den) : trial;
        data_next.work = {d_in.work[DIV_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= d_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        d_out       = data_reg;
        d_out.valid = valid_reg;
    end

endmodule

/* rtl/core/btpc_back.sv */
// Pressure correction after the division and output register.
module btpc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  btpc_pkg::div_stage_t div_in,
    input  btpc_pkg::coeff_t     coeff,
    output logic                 out_valid,
    output logic signed [31:0]   temperature_centi,
    output logic signed [31:0]   fine_temperature,
    output logic [31:0]          pressure_q24_8,
    output logic                 pressure_invalid
);
    import btpc_pkg::*;

    localparam int NSTG = 5;

    logic [NSTG-1:0] vld_reg;
    side_t           side_reg [1:NSTG];

    logic signed [63:0] b1_p_reg;
    logic signed [63:0] b2_p_reg, b2_ph_reg, b2_a_reg, b2_w2_reg;
    logic signed [63:0] b3_p_reg, b3_w2_reg;
    logic [63:0]        b3_lo_reg;
    logic [31:0]        b3_x_reg;
    logic signed [63:0] b4_sum_reg;
    logic [31:0]        b5_press_reg;

    logic signed [63:0] q;
    logic signed [63:0] ph;
    logic signed [63:0] w1;
    logic signed [63:0] res;

    assign q   = $signed(div_in.work);
    assign ph  = b1_p_reg >>> 13;
    assign w1  = $signed(b3_lo_reg + {b3_x_reg, 32'b0}) >>> 25;
    assign res = (b4_sum_reg >>> 8) + (64'(coeff.p7) <<< 4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], div_in.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[1] <= div_in.side;
            for (int k = 2; k <= NSTG; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            b1_p_reg  <= div_in.side.neg ? -q : q;
            b2_p_reg  <= b1_p_reg;
            b2_ph_reg <= ph;
            b2_a_reg  <= 64'(coeff.p9) * ph;
            b2_w2_reg <= (64'(coeff.p8) * b1_p_reg) >>> 19;
            // low 64 bits of a*ph from three 32x32 partial products
            b3_lo_reg <= 64'(b2_a_reg[31:0]) * 64'(b2_ph_reg[31:0]);
            b3_x_reg  <= b2_a_reg[63:32] * b2_ph_reg[31:0] + b2_a_reg[31:0] * b2_ph_reg[63:32];
            b3_p_reg  <= b2_p_reg;
            b3_w2_reg <= b2_w2_reg;
            b4_sum_reg <= b3_p_reg + w1 + b3_w2_reg;
            b5_press_reg <= side_reg[4].invalid ? 32'd0 : res[31:0];
        end
    end

    assign out_valid         = vld_reg[NSTG-1];
    assign temperature_centi = side_reg[NSTG].tc;
    assign fine_temperature  = side_reg[NSTG].tf;
    assign pressure_q24_8    = b5_press_reg;
    assign pressure_invalid  = side_reg[NSTG].invalid;

endmodule

/* rtl/core/baro_temp_pressure_compensation.sv */
// Top level: configuration registers, front pipeline, divider cell row, back pipeline.
// Fully pipelined: one raw sample pair is taken every cycle while s_tready is high;
// each passes through 11 front stages, 64 divider cells at one quotient bit each,
// and 5 back stages. The whole pipeline freezes while a result waits on m_tready, so
// s_tready is low exactly when the output register holds an untaken item.
// Calibration words must be written via the cfg channel only while the block is idle,
// not enforced by the block; cfg is always ready; all four registers reset to zero.
module baro_temp_pressure_compensation (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [btpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [63:0]                      cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [39:0]                      s_tdata,  // raw_pressure, raw_temperature
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // temperature_centi, fine_temperature, pressure_q24_8
    output logic [95:0]                      m_tdata,
    output logic [0:0]                       m_tuser   // pressure_invalid
);
    import btpc_pkg::*;

    logic [47:0] temp_coeffs_reg;
    logic [63:0] press_a_reg;
    logic [63:0] press_b_reg;
    logic [15:0] p9_reg;
    coeff_t      coeff;
    logic        en;

    div_stage_t chain [0:DIV_W];

    logic signed [31:0] temperature_centi;
    logic signed [31:0] fine_temperature;
    logic [31:0]        pressure_q24_8;
    logic               pressure_invalid;

    assign cfg_ready = 1'b1;
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeffs_reg <= '0;
            press_a_reg     <= '0;
            press_b_reg     <= '0;
            p9_reg          <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TEMP_COEFFS:    temp_coeffs_reg <= cfg_data[47:0];
                CFG_PRESS_COEFFS_A: press_a_reg     <= cfg_data;
                CFG_PRESS_COEFFS_B: press_b_reg     <= cfg_data;
                CFG_PRESS_COEFF_P9: p9_reg          <= cfg_data[15:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        coeff.t1 = temp_coeffs_reg[15:0];
        coeff.t2 = temp_coeffs_reg[31:16];
        coeff.t3 = temp_coeffs_reg[47:32];
        coeff.p1 = press_a_reg[15:0];
        coeff.p2 = press_a_reg[31:16];
        coeff.p3 = press_a_reg[47:32];
        coeff.p4 = press_a_reg[63:48];
        coeff.p5 = press_b_reg[15:0];
        coeff.p6 = press_b_reg[31:16];
        coeff.p7 = press_b_reg[47:32];
        coeff.p8 = press_b_reg[63:48];
        coeff.p9 = p9_reg;
    end

    btpc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_valid        (s_tvalid),
        .raw_pressure    (s_tdata[19:0]),
        .raw_temperature (s_tdata[39:20]),
        .coeff           (coeff),
        .div_out         (chain[0])
    );

    for (genvar i = 0; i < DIV_W; i++)
    begin : g_div
        btpc_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .d_in  (chain[i]),
            .d_out (chain[i+1])
        );
    end

    btpc_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .en                (en),
        .div_in            (chain[DIV_W]),
        .coeff             (coeff),
        .out_valid         (m_tvalid),
        .temperature_centi (temperature_centi),
        .fine_temperature  (fine_temperature),
        .pressure_q24_8    (pressure_q24_8),
        .pressure_invalid  (pressure_invalid)
    );

    assign m_tdata = {pressure_q24_8, fine_temperature, temperature_centi};
    assign m_tuser = pressure_invalid;

`ifndef ASSERT_OFF
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[95:64] == 32'd0)
        else $error("invalid pressure not forced to zero");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output changed while stalled");

    a_div_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(chain[DIV_W].valid) && $stable(chain[DIV_W].work))
        else $error("divider advanced during stall");
`endif

endmodule
